>>> sv/rti_pkg.sv
// Shared types, constants and width helpers for the ray/triangle intersection unit.
// Used by every module of the block; depends on nothing.
package rti_pkg;

    // Default field widths.
    localparam int COORD_BITS_DEF      = 32;
    localparam int FACE_INDEX_BITS_DEF = 16;

    // Distance output format: unsigned Q15.16 held in 31 bits.
    localparam int DIST_BITS = 31;
    localparam int FRAC_BITS = 16;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_DIRECTION_X = 3'd3,
        CFG_DIRECTION_Y = 3'd4,
        CFG_DIRECTION_Z = 3'd5
    } t_cfg_index;

    // Control that travels beside the data of one transaction.
    typedef struct packed {
        logic valid;   // stage holds a transaction
        logic ok;      // still a candidate for a hit
    } t_ctl;

    // Width of a dot product of a cross product with a coordinate difference.
    function automatic int prod_width(input int coord_bits);
        return 3 * coord_bits + 6;
    endfunction

    // Width of the division remainder path.
    function automatic int rem_width(input int coord_bits);
        return prod_width(coord_bits) + 32;
    endfunction

    // Cyclic component neighbors for cross products.
    function automatic int comp_next(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int comp_prev(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

endpackage

>>> sv/rti_geom.sv
// Geometry pipeline: edge vectors, two cross products and four dot products.
// Six register stages; depends on rti_pkg.
module rti_geom #(
    parameter int C_W = rti_pkg::COORD_BITS_DEF,
    parameter int F_W = rti_pkg::FACE_INDEX_BITS_DEF,
    localparam int P_W = rti_pkg::prod_width(C_W)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rti_pkg::t_ctl       i_ctl,
    input  logic [F_W-1:0]      i_face,
    input  logic signed [C_W-1:0] i_ca  [3],
    input  logic signed [C_W-1:0] i_cb  [3],
    input  logic signed [C_W-1:0] i_cc  [3],
    input  logic signed [C_W-1:0] i_org [3],
    input  logic signed [C_W-1:0] i_dir [3],
    output rti_pkg::t_ctl       o_ctl,
    output logic [F_W-1:0]      o_face,
    output logic signed [P_W-1:0] o_det,
    output logic signed [P_W-1:0] o_nu,
    output logic signed [P_W-1:0] o_nv,
    output logic signed [P_W-1:0] o_nt
);

    localparam int D_W = C_W + 1;       // coordinate difference
    localparam int X_W = 2 * D_W + 1;   // cross product component
    localparam int M_W = 2 * D_W + 1;   // partial product
    localparam int NS  = 6;             // stages in this module

    // Vector slots, ordered as the partner of each dot product.
    localparam int V_E1 = 0;
    localparam int V_S  = 1;
    localparam int V_D  = 2;
    localparam int V_E2 = 3;

    rti_pkg::t_ctl r_ctl  [NS];
    logic [F_W-1:0] r_face [NS];

    logic signed [D_W-1:0] c_v  [4][3];
    logic signed [D_W-1:0] r_v1 [4][3];
    logic signed [D_W-1:0] r_v2 [4][3];
    logic signed [D_W-1:0] r_v3 [4][3];
    logic signed [2*D_W-1:0] r_pa [3];
    logic signed [2*D_W-1:0] r_pb [3];
    logic signed [2*D_W-1:0] r_qa [3];
    logic signed [2*D_W-1:0] r_qb [3];
    logic signed [X_W-1:0] r_h [3];
    logic signed [X_W-1:0] r_q [3];
    logic signed [X_W-1:0] c_x [4][3];
    logic signed [M_W-1:0] r_lo [4][3];
    logic signed [M_W-1:0] r_hi [4][3];
    logic signed [P_W-1:0] r_term [4][3];
    logic signed [P_W-1:0] r_sum [4];

    // Edge and origin vectors relative to the first corner.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_v[V_E1][k] = D_W'(i_cb[k]) - D_W'(i_ca[k]);
            c_v[V_E2][k] = D_W'(i_cc[k]) - D_W'(i_ca[k]);
            c_v[V_S][k]  = D_W'(i_org[k]) - D_W'(i_ca[k]);
            c_v[V_D][k]  = D_W'(i_dir[k]);
        end
    end

    // Cross product operand for each dot product: h for det and nu, q for nv and nt.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                c_x[j][k] = (j < 2) ? r_h[k] : r_q[k];
            end
        end
    end

    // Control and face index travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < NS; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        r_face[0] <= i_face;
        for (int s = 1; s < NS; s++) begin
            r_face[s] <= r_face[s-1];
        end

        r_v1 <= c_v;
        r_v2 <= r_v1;
        r_v3 <= r_v2;

        for (int k = 0; k < 3; k++) begin
            // Products of h = d x e2 and q = s x e1.
            r_pa[k] <= r_v1[V_D][rti_pkg::comp_next(k)] * r_v1[V_E2][rti_pkg::comp_prev(k)];
            r_pb[k] <= r_v1[V_D][rti_pkg::comp_prev(k)] * r_v1[V_E2][rti_pkg::comp_next(k)];
            r_qa[k] <= r_v1[V_S][rti_pkg::comp_next(k)] * r_v1[V_E1][rti_pkg::comp_prev(k)];
            r_qb[k] <= r_v1[V_S][rti_pkg::comp_prev(k)] * r_v1[V_E1][rti_pkg::comp_next(k)];

            r_h[k] <= X_W'(r_pa[k]) - X_W'(r_pb[k]);
            r_q[k] <= X_W'(r_qa[k]) - X_W'(r_qb[k]);
        end

        // Dot products: each wide factor is split into two partial products.
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[j][k] <= $signed({1'b0, c_x[j][k][D_W-1:0]}) * r_v3[j][k];
                r_hi[j][k] <= $signed(c_x[j][k][X_W-1:D_W]) * r_v3[j][k];
                r_term[j][k] <= (P_W'(r_hi[j][k]) <<< D_W) + P_W'(r_lo[j][k]);
            end
            r_sum[j] <= r_term[j][0] + r_term[j][1] + r_term[j][2];
        end
    end

    assign o_ctl  = r_ctl[NS-1];
    assign o_face = r_face[NS-1];
    assign o_det  = r_sum[0];
    assign o_nu   = r_sum[1];
    assign o_nv   = r_sum[2];
    assign o_nt   = r_sum[3];

endmodule

>>> sv/rti_test.sv
// Sign normalization, barycentric and distance-sign tests, and division setup.
// Two register stages; depends on rti_pkg.
module rti_test #(
    parameter int C_W = rti_pkg::COORD_BITS_DEF,
    parameter int F_W = rti_pkg::FACE_INDEX_BITS_DEF,
    localparam int P_W = rti_pkg::prod_width(C_W),
    localparam int R_W = rti_pkg::rem_width(C_W)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rti_pkg::t_ctl         i_ctl,
    input  logic [F_W-1:0]        i_face,
    input  logic signed [P_W-1:0] i_det,
    input  logic signed [P_W-1:0] i_nu,
    input  logic signed [P_W-1:0] i_nv,
    input  logic signed [P_W-1:0] i_nt,
    output rti_pkg::t_ctl         o_ctl,
    output logic [F_W-1:0]        o_face,
    output logic [R_W-1:0]        o_num,
    output logic [R_W-1:0]        o_den,
    output logic                  o_sat
);

    rti_pkg::t_ctl r_ctl1, r_ctl2;
    logic [F_W-1:0] r_face1, r_face2;
    logic signed [P_W-1:0] r_det, r_nu, r_nv, r_nt;
    logic [R_W-1:0] r_num, r_den;
    logic r_sat;

    logic signed [P_W:0]   c_dnu;
    logic signed [P_W+1:0] c_duv;
    logic [R_W-1:0] c_num, c_den;
    logic c_pass;

    // Tests on the normalized (positive determinant) values.
    always_comb begin
        c_dnu  = (P_W+1)'(r_det) - (P_W+1)'(r_nu);
        c_duv  = (P_W+2)'(r_det) - (P_W+2)'(r_nu) - (P_W+2)'(r_nv);
        c_num  = {{(R_W-P_W){1'b0}}, r_nt} << rti_pkg::FRAC_BITS;
        c_den  = {{(R_W-P_W){1'b0}}, r_det};
        c_pass = !r_nu[P_W-1] && !c_dnu[P_W] && !r_nv[P_W-1] && !c_duv[P_W+1]
                 && !r_nt[P_W-1] && (r_nt != '0);
    end

    // Valid bits clear in reset; the data stages load every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
        end else begin
            r_ctl1.valid <= i_ctl.valid;
            r_ctl2.valid <= r_ctl1.valid;
        end

        // Flip every sign when the determinant is negative.
        r_ctl1.ok <= i_ctl.ok && (i_det != '0);
        r_face1   <= i_face;
        r_det     <= i_det[P_W-1] ? -i_det : i_det;
        r_nu      <= i_det[P_W-1] ? -i_nu  : i_nu;
        r_nv      <= i_det[P_W-1] ? -i_nv  : i_nv;
        r_nt      <= i_det[P_W-1] ? -i_nt  : i_nt;

        // Inside tests and saturation check against den shifted past the top quotient bit.
        r_ctl2.ok <= r_ctl1.ok && c_pass;
        r_face2   <= r_face1;
        r_num     <= c_num;
        r_den     <= c_den;
        r_sat     <= c_num >= (c_den << rti_pkg::DIST_BITS);
    end

    assign o_ctl  = r_ctl2;
    assign o_face = r_face2;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_sat  = r_sat;

endmodule

>>> sv/rti_div.sv
// Restoring divider, one quotient bit per pipeline stage, for the hit distance.
// Depends on rti_pkg.
module rti_div #(
    parameter int C_W = rti_pkg::COORD_BITS_DEF,
    parameter int F_W = rti_pkg::FACE_INDEX_BITS_DEF,
    localparam int R_W = rti_pkg::rem_width(C_W),
    localparam int QB  = rti_pkg::DIST_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rti_pkg::t_ctl   i_ctl,
    input  logic [F_W-1:0]  i_face,
    input  logic [R_W-1:0]  i_num,
    input  logic [R_W-1:0]  i_den,
    input  logic            i_sat,
    output rti_pkg::t_ctl   o_ctl,
    output logic [F_W-1:0]  o_face,
    output logic [QB-1:0]   o_quo,
    output logic            o_sat
);

    rti_pkg::t_ctl  r_ctl  [QB];
    logic [F_W-1:0] r_face [QB];
    logic [R_W-1:0] r_rem  [QB];
    logic [R_W-1:0] r_den  [QB];
    logic [QB-1:0]  r_quo  [QB];
    logic           r_sat  [QB];

    rti_pkg::t_ctl  c_ctl  [QB];
    logic [F_W-1:0] c_face [QB];
    logic [R_W-1:0] c_rem  [QB];
    logic [R_W-1:0] c_den  [QB];
    logic [QB-1:0]  c_quo  [QB];
    logic           c_sat  [QB];
    logic [R_W-1:0] c_part [QB];
    logic           c_ge   [QB];

    // Inputs of each stage: the module inputs, then the stage before.
    always_comb begin
        c_ctl[0]  = i_ctl;
        c_face[0] = i_face;
        c_rem[0]  = i_num;
        c_den[0]  = i_den;
        c_quo[0]  = '0;
        c_sat[0]  = i_sat;
        for (int i = 1; i < QB; i++) begin
            c_ctl[i]  = r_ctl[i-1];
            c_face[i] = r_face[i-1];
            c_rem[i]  = r_rem[i-1];
            c_den[i]  = r_den[i-1];
            c_quo[i]  = r_quo[i-1];
            c_sat[i]  = r_sat[i-1];
        end
        // Stage i decides quotient bit QB-1-i.
        for (int i = 0; i < QB; i++) begin
            c_part[i] = c_den[i] << (QB - 1 - i);
            c_ge[i]   = c_rem[i] >= c_part[i];
        end
    end

    // Valid bits clear in reset; the data stages load every cycle.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QB; i++) begin
            if (!i_rst_n) begin
                r_ctl[i].valid <= 1'b0;
            end else begin
                r_ctl[i].valid <= c_ctl[i].valid;
            end
            r_ctl[i].ok <= c_ctl[i].ok;
            r_face[i]   <= c_face[i];
            r_den[i]    <= c_den[i];
            r_sat[i]    <= c_sat[i];
            r_rem[i]    <= c_ge[i] ? c_rem[i] - c_part[i] : c_rem[i];
            r_quo[i]    <= c_quo[i] | (QB'(c_ge[i]) << (QB - 1 - i));
        end
    end

    assign o_ctl  = r_ctl[QB-1];
    assign o_face = r_face[QB-1];
    assign o_quo  = r_quo[QB-1];
    assign o_sat  = r_sat[QB-1];

endmodule

>>> sv/ray_triangle_intersect.sv
// Ray/triangle intersection unit: one triangle per clock against a configured ray.
// The path from the accepting edge to the result strobe holds 40 register stages;
// throughput one transaction per cycle, set by the pipelined multipliers and 31-stage divider.
// busy is high only during reset; results cannot be stalled by the receiver.
// Synchronous active-low reset clears all valid bits and the ray registers to zero.
// Depends on rti_pkg, rti_geom, rti_test and rti_div.
module ray_triangle_intersect #(
    parameter int COORD_BITS      = rti_pkg::COORD_BITS_DEF,
    parameter int FACE_INDEX_BITS = rti_pkg::FACE_INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_corner_a_x,
    input  logic signed [COORD_BITS-1:0]        i_corner_a_y,
    input  logic signed [COORD_BITS-1:0]        i_corner_a_z,
    input  logic signed [COORD_BITS-1:0]        i_corner_b_x,
    input  logic signed [COORD_BITS-1:0]        i_corner_b_y,
    input  logic signed [COORD_BITS-1:0]        i_corner_b_z,
    input  logic signed [COORD_BITS-1:0]        i_corner_c_x,
    input  logic signed [COORD_BITS-1:0]        i_corner_c_y,
    input  logic signed [COORD_BITS-1:0]        i_corner_c_z,
    input  logic [FACE_INDEX_BITS-1:0]          i_face_number,
    input  logic                                i_face_valid,
    input  logic                                i_cfg_we,
    input  logic [rti_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_hit,
    output logic [rti_pkg::DIST_BITS-1:0]       o_hit_distance,
    output logic [FACE_INDEX_BITS-1:0]          o_hit_face
);

    localparam int P_W = rti_pkg::prod_width(COORD_BITS);
    localparam int R_W = rti_pkg::rem_width(COORD_BITS);

    logic signed [COORD_BITS-1:0] r_org [3];
    logic signed [COORD_BITS-1:0] r_dir [3];
    logic signed [COORD_BITS-1:0] c_ca [3], c_cb [3], c_cc [3];

    rti_pkg::t_ctl c_in_ctl, g_ctl, t_ctl_o, d_ctl;
    logic [FACE_INDEX_BITS-1:0] g_face, t_face, d_face;
    logic signed [P_W-1:0] g_det, g_nu, g_nv, g_nt;
    logic [R_W-1:0] t_num, t_den;
    logic t_sat, d_sat;
    logic [rti_pkg::DIST_BITS-1:0] d_quo, c_dist;
    logic c_hit;

    logic r_result_valid, r_hit;
    logic [rti_pkg::DIST_BITS-1:0] r_dist;
    logic [FACE_INDEX_BITS-1:0] r_face;

    // A transaction is taken in any cycle outside reset in which start is high.
    assign busy     = ~i_rst_n;
    assign c_in_ctl = '{valid: start && !busy, ok: i_face_valid};

    assign c_ca = '{i_corner_a_x, i_corner_a_y, i_corner_a_z};
    assign c_cb = '{i_corner_b_x, i_corner_b_y, i_corner_b_z};
    assign c_cc = '{i_corner_c_x, i_corner_c_y, i_corner_c_z};

    // Ray registers, written by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rti_pkg::CFG_ORIGIN_X:    r_org[0] <= i_cfg_data;
                rti_pkg::CFG_ORIGIN_Y:    r_org[1] <= i_cfg_data;
                rti_pkg::CFG_ORIGIN_Z:    r_org[2] <= i_cfg_data;
                rti_pkg::CFG_DIRECTION_X: r_dir[0] <= i_cfg_data;
                rti_pkg::CFG_DIRECTION_Y: r_dir[1] <= i_cfg_data;
                rti_pkg::CFG_DIRECTION_Z: r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rti_geom #(.C_W(COORD_BITS), .F_W(FACE_INDEX_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_in_ctl),
        .i_face  (i_face_number),
        .i_ca    (c_ca),
        .i_cb    (c_cb),
        .i_cc    (c_cc),
        .i_org   (r_org),
        .i_dir   (r_dir),
        .o_ctl   (g_ctl),
        .o_face  (g_face),
        .o_det   (g_det),
        .o_nu    (g_nu),
        .o_nv    (g_nv),
        .o_nt    (g_nt)
    );

    rti_test #(.C_W(COORD_BITS), .F_W(FACE_INDEX_BITS)) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (g_ctl),
        .i_face  (g_face),
        .i_det   (g_det),
        .i_nu    (g_nu),
        .i_nv    (g_nv),
        .i_nt    (g_nt),
        .o_ctl   (t_ctl_o),
        .o_face  (t_face),
        .o_num   (t_num),
        .o_den   (t_den),
        .o_sat   (t_sat)
    );

    rti_div #(.C_W(COORD_BITS), .F_W(FACE_INDEX_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (t_ctl_o),
        .i_face  (t_face),
        .i_num   (t_num),
        .i_den   (t_den),
        .i_sat   (t_sat),
        .o_ctl   (d_ctl),
        .o_face  (d_face),
        .o_quo   (d_quo),
        .o_sat   (d_sat)
    );

    // Saturate, then require at least one Q15.16 step of distance.
    assign c_dist = d_sat ? rti_pkg::DIST_MAX : d_quo;
    assign c_hit  = d_ctl.ok && (c_dist != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
            r_hit          <= 1'b0;
        end else begin
            r_result_valid <= d_ctl.valid;
            r_hit          <= d_ctl.valid && c_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= c_hit ? c_dist : '0;
        r_face <= d_face;
    end

    assign o_result_valid = r_result_valid;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;
    assign o_hit_face     = r_face;

`ifndef SYNTHESIS
    // A hit always carries a nonzero distance.
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_hit_distance != '0)
        else $error("hit with zero distance");

    // A miss reports zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_hit) |-> o_hit_distance == '0)
        else $error("miss with nonzero distance");

    // The hit flag only rises together with the result strobe.
    a_hit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_result_valid)
        else $error("hit outside a result transaction");
`endif

endmodule
